[sv/nec_ir_pulse_decoder_core_macros.svh]
// ----------------------------------------------------------------------------
// nec ir pulse decoder assertion macros
// concurrent assertion helpers, empty when synthesized
// ----------------------------------------------------------------------------
`ifndef NEC_IR_PULSE_DECODER_CORE_MACROS_SVH
`define NEC_IR_PULSE_DECODER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[sv/nirpd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nirpd_pkg
// shared types and constants of the nec ir pulse decoder
// ----------------------------------------------------------------------------
package nirpd_pkg;

  localparam int OP_W      = 2;
  localparam int TIME_W    = 14;
  localparam int BYTE_W    = 8;
  localparam int OVF_W     = 4;
  localparam int FRAME_W   = 32;
  localparam int IN_DATA_W = 16;
  localparam int OUT_DATA_W = 24;

  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // pulse windows in microseconds, exclusive at both ends
  localparam logic [TIME_W-1:0] BIT0_LO   = 14'd300;
  localparam logic [TIME_W-1:0] BIT0_HI   = 14'd800;
  localparam logic [TIME_W-1:0] BIT1_LO   = 14'd1400;
  localparam logic [TIME_W-1:0] BIT1_HI   = 14'd1800;
  localparam logic [TIME_W-1:0] REPEAT_LO = 14'd2200;
  localparam logic [TIME_W-1:0] REPEAT_HI = 14'd2600;
  localparam logic [TIME_W-1:0] LEADER_LO = 14'd4200;
  localparam logic [TIME_W-1:0] LEADER_HI = 14'd4700;

  localparam logic [OVF_W-1:0] OVF_LIMIT = 4'd14;

  typedef enum logic [OP_W-1:0] {
    OP_RISE = 2'd0,
    OP_FALL = 2'd1,
    OP_OVF  = 2'd2,
    OP_SCAN = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    PULSE_NONE,
    PULSE_BIT0,
    PULSE_BIT1,
    PULSE_REPEAT,
    PULSE_LEADER
  } pulse_t;

  typedef struct packed {
    op_t    op;
    pulse_t pulse;
  } event_t;

  function automatic pulse_t classify(input logic [TIME_W-1:0] t);
    pulse_t p;
    p = PULSE_NONE;
    if (t > BIT0_LO && t < BIT0_HI) begin
      p = PULSE_BIT0;
    end else if (t > BIT1_LO && t < BIT1_HI) begin
      p = PULSE_BIT1;
    end else if (t > REPEAT_LO && t < REPEAT_HI) begin
      p = PULSE_REPEAT;
    end else if (t > LEADER_LO && t < LEADER_HI) begin
      p = PULSE_LEADER;
    end
    return p;
  endfunction

endpackage

[sv/nec_ir_pulse_decoder_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nec_ir_pulse_decoder_core
// nec infrared remote receiver: pulse classification and frame checking
// ----------------------------------------------------------------------------
// usage:
//   s_* carries one event per transfer: tuser is the operation (rising edge,
//   falling edge, overflow tick, scan), tdata the measured high time in us.
//   m_* returns exactly one result per event: key code (nonzero only for a
//   scan of a valid frame), repeat count and the leader flag after the event.
//   cfg_* writes the expected remote address byte; cfg_ready is always high.
//   a result passes the event queue register and then the result register
//   before it is valid at m_*.
//   throughput: one event per cycle while m_tready stays high, set by the
//   state update in the back end.
//   when m_tready is low the result register holds, the queue fills and
//   s_tready drops once it is full; no event is lost.
//   reset clears all receiver state, the address register and the queue.
// ----------------------------------------------------------------------------
module nec_ir_pulse_decoder_core import nirpd_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [13:0] high_time, [15:14] zero
  input  logic [OP_W-1:0]       s_tuser,   // [1:0] operation
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [7:0] key_code, [15:8] repeat_count,
                                           // [16] leader_seen, [23:17] zero
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [BYTE_W-1:0]     cfg_data   // [7:0] remote_address
);

  logic   push_valid;
  logic   push_ready;
  event_t push_event;
  logic   pop_valid;
  logic   pop_ready;
  event_t pop_event;

  assign cfg_ready = 1'b1;

  nirpd_front u_front (
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_event(push_event)
  );

  nirpd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (push_valid),
    .in_ready (push_ready),
    .in_event (push_event),
    .out_valid(pop_valid),
    .out_ready(pop_ready),
    .out_event(pop_event)
  );

  nirpd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_data (cfg_data),
    .in_valid (pop_valid),
    .in_ready (pop_ready),
    .in_event (pop_event),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

[sv/nirpd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nirpd_front
// accepts input events and classifies the pulse high time
// ----------------------------------------------------------------------------
module nirpd_front import nirpd_pkg::*; (
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_DATA_W-1:0] s_tdata,   // [13:0] high_time, [15:14] zero
  input  logic [OP_W-1:0]      s_tuser,   // [1:0] operation
  output logic                 push_valid,
  input  logic                 push_ready,
  output event_t               push_event
);

  assign s_tready   = push_ready;
  assign push_valid = s_tvalid;

  always_comb begin
    push_event.op    = op_t'(s_tuser);
    push_event.pulse = classify(s_tdata[TIME_W-1:0]);
  end

endmodule

[sv/nirpd_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nirpd_queue
// short register queue of classified events between front and back
// ----------------------------------------------------------------------------
`include "nec_ir_pulse_decoder_core_macros.svh"

module nirpd_queue import nirpd_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  event_t in_event,
  output logic   out_valid,
  input  logic   out_ready,
  output event_t out_event
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  event_t             entries [DEPTH];
  logic [IDX_W-1:0]   wr_ptr;
  logic [IDX_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               push;
  logic               pop;

  assign in_ready  = (count != CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign out_event = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_event;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `ASSERT_IMPLY(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(DEPTH))
  `ASSERT_NEXT(a_count_up, clk, rst, push && !pop, count == CNT_W'($past(count) + 1'b1))
  `ASSERT_NEXT(a_count_down, clk, rst, pop && !push, count == CNT_W'($past(count) - 1'b1))

endmodule

[sv/nirpd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nirpd_back
// receiver state update and registered result stage
// ----------------------------------------------------------------------------
`include "nec_ir_pulse_decoder_core_macros.svh"

module nirpd_back import nirpd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [BYTE_W-1:0]     cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  event_t                in_event,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata  // [7:0] key_code, [15:8] repeat_count,
                                          // [16] leader_seen, [23:17] zero
);

  logic [BYTE_W-1:0]  remote_address;
  logic               leader_flag;
  logic               key_ready_flag;
  logic               edge_captured_flag;
  logic [OVF_W-1:0]   overflow_count;
  logic [FRAME_W-1:0] frame_shift;
  logic [BYTE_W-1:0]  repeats;
  logic [BYTE_W-1:0]  key_code;

  logic               leader_flag_next;
  logic               key_ready_flag_next;
  logic               edge_captured_flag_next;
  logic [OVF_W-1:0]   overflow_count_next;
  logic [FRAME_W-1:0] frame_shift_next;
  logic [BYTE_W-1:0]  repeats_next;
  logic [BYTE_W-1:0]  key_code_next;

  logic               take;
  logic [BYTE_W-1:0]  addr_byte;
  logic [BYTE_W-1:0]  addr_inv;
  logic [BYTE_W-1:0]  cmd_byte;
  logic [BYTE_W-1:0]  cmd_inv;
  logic               frame_ok;

  // the result register frees whenever its transfer completes
  assign in_ready = !m_tvalid || m_tready;
  assign take     = in_valid && in_ready;

  assign addr_byte = frame_shift[31:24];
  assign addr_inv  = frame_shift[23:16];
  assign cmd_byte  = frame_shift[15:8];
  assign cmd_inv   = frame_shift[7:0];
  assign frame_ok  = (addr_byte == ~addr_inv) && (addr_byte == remote_address)
                     && (cmd_byte == ~cmd_inv);

  always_comb begin
    leader_flag_next        = leader_flag;
    key_ready_flag_next     = key_ready_flag;
    edge_captured_flag_next = edge_captured_flag;
    overflow_count_next     = overflow_count;
    frame_shift_next        = frame_shift;
    repeats_next            = repeats;
    key_code_next           = '0;
    case (in_event.op)
      OP_RISE: begin
        edge_captured_flag_next = 1'b1;
      end
      OP_FALL: begin
        edge_captured_flag_next = 1'b0;
        if (edge_captured_flag) begin
          if (leader_flag) begin
            case (in_event.pulse)
              PULSE_BIT0:   frame_shift_next = {frame_shift[FRAME_W-2:0], 1'b0};
              PULSE_BIT1:   frame_shift_next = {frame_shift[FRAME_W-2:0], 1'b1};
              PULSE_REPEAT: begin
                repeats_next        = repeats + 1'b1;
                overflow_count_next = '0;
              end
              default: ;
            endcase
          end else if (in_event.pulse == PULSE_LEADER) begin
            leader_flag_next = 1'b1;
            repeats_next     = '0;
          end
        end
      end
      OP_OVF: begin
        if (leader_flag) begin
          edge_captured_flag_next = 1'b0;
          if (overflow_count == '0) begin
            key_ready_flag_next = 1'b1;
          end
          if (overflow_count < OVF_LIMIT) begin
            overflow_count_next = overflow_count + 1'b1;
          end else begin
            leader_flag_next    = 1'b0;
            overflow_count_next = '0;
          end
        end
      end
      OP_SCAN: begin
        if (key_ready_flag) begin
          key_code_next = frame_ok ? cmd_byte : '0;
          // a zero command reads the same as a failed check
          if (!frame_ok || cmd_byte == '0 || !leader_flag) begin
            key_ready_flag_next = 1'b0;
            repeats_next        = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remote_address     <= '0;
      leader_flag        <= 1'b0;
      key_ready_flag     <= 1'b0;
      edge_captured_flag <= 1'b0;
      overflow_count     <= '0;
      frame_shift        <= '0;
      repeats            <= '0;
      m_tvalid           <= 1'b0;
    end else begin
      if (cfg_valid) begin
        remote_address <= cfg_data;
      end
      if (take) begin
        leader_flag        <= leader_flag_next;
        key_ready_flag     <= key_ready_flag_next;
        edge_captured_flag <= edge_captured_flag_next;
        overflow_count     <= overflow_count_next;
        frame_shift        <= frame_shift_next;
        repeats            <= repeats_next;
        m_tvalid           <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      key_code <= key_code_next;
    end
  end

  assign m_tdata = {7'd0, leader_flag, repeats, key_code};

  `ASSERT_IMPLY(a_ovf_idle, clk, rst, !leader_flag, overflow_count == '0)
  `ASSERT_IMPLY(a_ovf_limit, clk, rst, 1'b1, overflow_count <= OVF_LIMIT)
  `ASSERT_NEXT(a_scan_not_ready, clk, rst, take && in_event.op == OP_SCAN && !key_ready_flag, key_code == '0 && repeats == $past(repeats))

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives ir events into nec_ir_pulse_decoder_core, predicts every result with
// a behavioral copy of the receiver state and checks each output transfer
// ----------------------------------------------------------------------------
module testbench;
  import nirpd_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] key_code;
    logic [BYTE_W-1:0] repeat_count;
    logic              leader_seen;
  } ir_report_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // [13:0] high_time, [15:14] zero
  logic [OP_W-1:0]       s_tuser = '0;   // [1:0] operation
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;        // [7:0] key_code, [15:8] repeat_count,
                                         // [16] leader_seen
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [BYTE_W-1:0]     cfg_data = '0;  // [7:0] remote_address

  // predicted receiver state
  logic [BYTE_W-1:0]  ir_address   = '0;
  logic               ir_leader    = 1'b0;
  logic               ir_key_ready = 1'b0;
  logic               ir_edge_held = 1'b0;
  logic [OVF_W-1:0]   ir_ovf_count = '0;
  logic [FRAME_W-1:0] ir_frame     = '0;
  logic [BYTE_W-1:0]  ir_repeats   = '0;

  ir_report_t awaited_reports[$];
  int         fail_count  = 0;
  int         events_sent = 0;
  bit         sender_idles = 1'b1;
  bit         recv_idles   = 1'b1;
  int         recv_hold    = 0;

  nec_ir_pulse_decoder_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(8, 40);
    end
    return $urandom_range(1, 3);
  endfunction

  // next receiver state and the report one event produces
  function automatic ir_report_t decode_ir_event(op_t op, logic [TIME_W-1:0] t);
    ir_report_t rpt;
    logic [BYTE_W-1:0] addr_b, addr_n, cmd_b, cmd_n;
    rpt = '0;
    case (op)
      OP_RISE: begin
        ir_edge_held = 1'b1;
      end
      OP_FALL: begin
        if (ir_edge_held) begin
          if (ir_leader) begin
            if (t > BIT0_LO && t < BIT0_HI) begin
              ir_frame = {ir_frame[FRAME_W-2:0], 1'b0};
            end else if (t > BIT1_LO && t < BIT1_HI) begin
              ir_frame = {ir_frame[FRAME_W-2:0], 1'b1};
            end else if (t > REPEAT_LO && t < REPEAT_HI) begin
              ir_repeats   = ir_repeats + 8'd1;
              ir_ovf_count = '0;
            end
          end else if (t > LEADER_LO && t < LEADER_HI) begin
            ir_leader  = 1'b1;
            ir_repeats = '0;
          end
        end
        ir_edge_held = 1'b0;
      end
      OP_OVF: begin
        if (ir_leader) begin
          ir_edge_held = 1'b0;
          if (ir_ovf_count == 0) begin
            ir_key_ready = 1'b1;
          end
          if (ir_ovf_count < OVF_LIMIT) begin
            ir_ovf_count = ir_ovf_count + 4'd1;
          end else begin
            ir_leader    = 1'b0;
            ir_ovf_count = '0;
          end
        end
      end
      default: begin
        if (ir_key_ready) begin
          addr_b = ir_frame[31:24];
          addr_n = ir_frame[23:16];
          cmd_b  = ir_frame[15:8];
          cmd_n  = ir_frame[7:0];
          if (addr_b == ~addr_n && addr_b == ir_address && cmd_b == ~cmd_n) begin
            rpt.key_code = cmd_b;
          end
          if (rpt.key_code == 0 || !ir_leader) begin
            ir_key_ready = 1'b0;
            ir_repeats   = '0;
          end
        end
      end
    endcase
    rpt.repeat_count = ir_repeats;
    rpt.leader_seen  = ir_leader;
    return rpt;
  endfunction

  task automatic send_event(input op_t op, input logic [TIME_W-1:0] t);
    int gap;
    gap = 0;
    if (sender_idles && $urandom_range(0, 2) == 0) begin
      gap = pick_gap();
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {2'b00, t};
    do @(posedge clk); while (!s_tready);
    awaited_reports.push_back(decode_ir_event(op, t));
    events_sent++;
  endtask

  task automatic send_pulse(input logic [TIME_W-1:0] t);
    send_event(OP_RISE, TIME_W'($urandom_range(0, 10000)));
    send_event(OP_FALL, t);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_event(OP_OVF, TIME_W'($urandom_range(0, 10000)));
  endtask

  task automatic send_scan();
    send_event(OP_SCAN, TIME_W'($urandom_range(0, 10000)));
  endtask

  // leader code then 32 data bits, msb first; flip >= 0 corrupts that bit
  task automatic send_frame(input logic [7:0] addr, input logic [7:0] cmd, input int flip);
    logic [FRAME_W-1:0] word;
    word = {addr, ~addr, cmd, ~cmd};
    if (flip >= 0) begin
      word[flip] = ~word[flip];
    end
    send_pulse(TIME_W'($urandom_range(4201, 4699)));
    for (int i = FRAME_W - 1; i >= 0; i--) begin
      send_pulse(TIME_W'(word[i] ? $urandom_range(1401, 1799) : $urandom_range(301, 799)));
    end
  endtask

  function automatic logic [TIME_W-1:0] random_time();
    int bounds[8] = '{300, 800, 1400, 1800, 2200, 2600, 4200, 4700};
    if ($urandom_range(0, 1) == 0) begin
      return TIME_W'($urandom_range(0, 10000));
    end
    return TIME_W'(bounds[$urandom_range(0, 7)] + $urandom_range(0, 2) - 1);
  endfunction

  task automatic wait_drained();
    while (awaited_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_address(input logic [7:0] a);
    s_tvalid <= 1'b0;
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= a;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    ir_address = a;
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      fail_count++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  initial begin : result_checker
    ir_report_t want;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        if (awaited_reports.size() == 0) begin
          fail_count++;
          $error("result transfer with nothing expected: %h", m_tdata);
        end else begin
          want = awaited_reports.pop_front();
          check_field("key_code", want.key_code, m_tdata[7:0]);
          check_field("repeat_count", want.repeat_count, m_tdata[15:8]);
          check_field("leader_seen", {7'd0, want.leader_seen}, {7'd0, m_tdata[16]});
        end
      end
    end
  end

  initial begin : result_sink
    int n;
    forever begin
      if (recv_hold > 0) begin
        n = recv_hold;
        recv_hold = 0;
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (recv_idles && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat (pick_gap()) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic test_corner_events();
    sender_idles = 1'b1;
    recv_idles   = 1'b1;
    send_event(OP_FALL, 14'd500);      // falling edge with no rising edge before it
    send_pulse(14'd500);               // data bit before any leader
    send_pulse(14'd2400);              // repeat before any leader
    send_event(OP_OVF, 14'd0);         // tick with no leader
    send_scan();                       // nothing ready
    send_pulse(14'h3FFF);              // beyond the nominal range
    send_pulse(LEADER_HI);             // window ends are exclusive
    send_pulse(14'd4201);
    send_pulse(14'd4500);              // second leader while leader set
    send_pulse(BIT0_HI);
    send_pulse(14'd2599);
    send_pulse(14'd0);
    send_event(OP_OVF, 14'd10000);
    send_scan();                       // all-zero frame fails the complement check
    send_event(OP_FALL, 14'd10000);
  endtask

  task automatic test_address_settings();
    logic [7:0] addrs[3];
    addrs = '{8'h00, 8'hFF, 8'($urandom_range(1, 254))};
    sender_idles = 1'b0;
    recv_idles   = 1'b1;
    foreach (addrs[i]) begin
      write_address(addrs[i]);
      send_frame(addrs[i], 8'hFF, -1);
      send_ticks(1);
      send_scan();
      send_pulse(TIME_W'($urandom_range(2201, 2599)));
      send_ticks(1);
      send_scan();
      send_frame(addrs[i], 8'h00, -1);  // command of zero never counts as a key
      send_scan();
      send_frame(~addrs[i], 8'h5A, -1);
      send_scan();
      send_ticks(15);                   // leader times out
      send_scan();
    end
  endtask

  task automatic test_repeat_wrap();
    sender_idles = 1'b1;
    recv_idles   = 1'b0;
    send_frame(ir_address, 8'($urandom_range(1, 255)), -1);
    send_ticks(1);
    send_scan();
    repeat (258) send_pulse(TIME_W'($urandom_range(2201, 2599)));
    send_ticks(1);
    send_scan();
  endtask

  task automatic test_backpressure();
    sender_idles = 1'b0;
    recv_idles   = 1'b0;
    s_tvalid <= 1'b0;
    @(posedge clk);
    recv_hold = 60;
    repeat (16) send_event(op_t'($urandom_range(0, 3)), random_time());
    s_tvalid <= 1'b0;
    wait_drained();
    recv_idles = 1'b1;
    repeat (6) send_event(op_t'($urandom_range(0, 3)), random_time());
  endtask

  task automatic test_random_traffic();
    int kind;
    int flip;
    logic [7:0] addr, cmd;
    while (events_sent < 1350) begin
      sender_idles = ($urandom_range(0, 3) != 0);
      recv_idles   = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 2))
          0:       write_address(8'h00);
          1:       write_address(8'hFF);
          default: write_address(8'($urandom()));
        endcase
      end
      kind = $urandom_range(0, 9);
      if (kind <= 4) begin
        addr = ($urandom_range(0, 9) < 7) ? ir_address : 8'($urandom());
        cmd  = ($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom());
        flip = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : -1;
        send_frame(addr, cmd, flip);
        send_ticks($urandom_range(1, 3));
        send_scan();
        repeat ($urandom_range(0, 4)) begin
          send_pulse(TIME_W'($urandom_range(2201, 2599)));
          send_ticks($urandom_range(0, 2));
          send_scan();
        end
        if ($urandom_range(0, 2) == 0) begin
          send_ticks($urandom_range(14, 16));
          send_scan();
        end
      end else if (kind <= 6) begin
        repeat ($urandom_range(5, 15)) begin
          send_event(op_t'($urandom_range(0, 3)), random_time());
        end
      end else if (kind == 7) begin
        // frame cut short and followed by a scan
        send_pulse(TIME_W'($urandom_range(4201, 4699)));
        repeat ($urandom_range(1, 31)) begin
          send_pulse(TIME_W'($urandom_range(0, 1) ? $urandom_range(1401, 1799)
                                                  : $urandom_range(301, 799)));
        end
        send_ticks($urandom_range(0, 2));
        send_scan();
      end else if (kind == 8) begin
        send_ticks($urandom_range(1, 16));
      end else begin
        repeat ($urandom_range(1, 3)) send_scan();
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_corner_events();
    test_address_settings();
    test_repeat_wrap();
    test_backpressure();
    test_random_traffic();
    s_tvalid <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/nirpd_pkg.sv
sv/nirpd_front.sv
sv/nirpd_queue.sv
sv/nirpd_back.sv
sv/nec_ir_pulse_decoder_core.sv
tb/testbench.sv
